// File: rtl/clt_pkg.sv
// Shared types, constants and helper functions of the command line tokenizer.
package clt_pkg;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharDquote    = 8'h22;
  localparam logic [7:0] CharSquote    = 8'h27;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharNewline   = 8'h0A;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_LINE_END  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_out;
    logic       last;
  } res_t;

  // Results of one accepted request, first result in r0.
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic quote_e quote_code(input logic [7:0] c);
    quote_e q;
    q = QUOTE_NONE;
    if (c == CharDquote) q = QUOTE_DOUBLE;
    else if (c == CharSquote) q = QUOTE_SINGLE;
    return q;
  endfunction

  function automatic logic [7:0] translate_escape(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CharN) r = CharNewline;
    else if (c == CharT) r = CharTab;
    return r;
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab);
  endfunction

endpackage

// File: rtl/clt_if.sv
// Request and result channel interfaces of the command line tokenizer.
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;

  modport source (output valid, output char_in, output end_of_line, input ready);
  modport sink (input valid, input char_in, input end_of_line, output ready);
endinterface

interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, output kind, output char_out, output last, input ready);
  modport sink (input valid, input kind, input char_out, input last, output ready);
endinterface

// File: rtl/clt_step.sv
// Tokenizer state registers and the per-byte decision logic.
module clt_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     char_i,
  input  logic           eol_i,
  output clt_pkg::push_t push_o
);
  import clt_pkg::*;

  logic   escape_q, escape_d;
  quote_e quote_q, quote_d;
  logic   open_q, open_d;
  quote_e qcode;

  assign qcode = quote_code(char_i);

  // Next state.
  always_comb begin
    escape_d = escape_q;
    quote_d  = quote_q;
    open_d   = open_q;
    if (accept_i) begin
      if (eol_i) begin
        escape_d = 1'b0;
        quote_d  = QUOTE_NONE;
        open_d   = 1'b0;
      end else if (escape_q) begin
        escape_d = 1'b0;
        open_d   = 1'b1;
      end else if (char_i == CharBackslash) begin
        escape_d = 1'b1;
      end else if (quote_q != QUOTE_NONE) begin
        if (qcode == quote_q) begin
          quote_d = QUOTE_NONE;
          open_d  = 1'b0;
        end else begin
          open_d = 1'b1;
        end
      end else if (qcode != QUOTE_NONE || is_separator(char_i)) begin
        open_d  = 1'b0;
        quote_d = qcode;
      end else begin
        open_d = 1'b1;
      end
    end
  end

  // Results.
  always_comb begin
    push_o = '0;
    if (eol_i) begin
      if (open_q || quote_q != QUOTE_NONE) begin
        push_o.num = 2'd2;
        push_o.r0  = '{kind: KIND_TOKEN_END, char_out: 8'h00, last: 1'b0};
        push_o.r1  = '{kind: KIND_LINE_END, char_out: 8'h00, last: 1'b1};
      end else begin
        push_o.num = 2'd1;
        push_o.r0  = '{kind: KIND_LINE_END, char_out: 8'h00, last: 1'b1};
      end
    end else if (escape_q) begin
      push_o.num = 2'd1;
      push_o.r0  = '{kind: KIND_CHAR, char_out: translate_escape(char_i), last: 1'b1};
    end else if (char_i == CharBackslash) begin
      push_o.num = 2'd0;
    end else if (quote_q != QUOTE_NONE) begin
      push_o.num = 2'd1;
      if (qcode == quote_q) begin
        push_o.r0 = '{kind: KIND_TOKEN_END, char_out: 8'h00, last: 1'b1};
      end else begin
        push_o.r0 = '{kind: KIND_CHAR, char_out: char_i, last: 1'b1};
      end
    end else if (qcode != QUOTE_NONE || is_separator(char_i)) begin
      if (open_q) begin
        push_o.num = 2'd1;
        push_o.r0  = '{kind: KIND_TOKEN_END, char_out: 8'h00, last: 1'b1};
      end
    end else begin
      push_o.num = 2'd1;
      push_o.r0  = '{kind: KIND_CHAR, char_out: char_i, last: 1'b1};
    end
    // Drop everything without an accepted request.
    if (!accept_i) push_o.num = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= 1'b0;
      quote_q  <= QUOTE_NONE;
      open_q   <= 1'b0;
    end else begin
      escape_q <= escape_d;
      quote_q  <= quote_d;
      open_q   <= open_d;
    end
  end

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && eol_i |=> !escape_q && quote_q == QUOTE_NONE && !open_q)
    else $error("state not cleared after end of line");

  a_two_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.num == 2'd2 |-> eol_i && push_o.r0.kind == KIND_TOKEN_END
                           && push_o.r1.kind == KIND_LINE_END)
    else $error("two results outside end of line");

  a_escape_no_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !eol_i && escape_q |=> quote_q == $past(quote_q))
    else $error("escaped byte changed quote state");

endmodule

// File: rtl/clt_result_fifo.sv
// Small result queue that takes up to two results per cycle and drains one when ready.
module clt_result_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  clt_pkg::push_t           push_i,
  output logic                     space_o,
  clt_out_if.source                res_o
);
  import clt_pkg::*;

  res_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  res_t            head;

  assign pop     = res_o.valid && res_o.ready;
  assign space_o = cnt_q <= CntW'(FifoDepth - 2);
  assign head    = mem_q[rd_q];

  assign res_o.valid    = cnt_q != '0;
  assign res_o.kind     = head.kind;
  assign res_o.char_out = head.char_out;
  assign res_o.last     = head.last;

  assign cnt_d = cnt_q + CntW'(push_i.num) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.num == 2'd2) mem_q[wr_q + PtrW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.num);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_push_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> space_o)
    else $error("push into full result queue");

  a_push_at_most_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd3)
    else $error("more than two results pushed in one cycle");

endmodule

// File: rtl/command_line_tokenizer_core.sv
// Results enter the result queue on acceptance and leave it in order. Throughput:
// one byte per cycle while req_i.ready is high, which is while the result queue
// has room for two results. Each byte gives at most one result; an end-of-line
// request with an open or quoted token gives two, which the single result port
// drains one at a time. Reset clears tokenizer state and empties the queue.
module command_line_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  clt_in_if.sink     req_i,
  clt_out_if.source  res_o
);
  import clt_pkg::*;

  logic  accept;
  logic  space;
  push_t push;

  assign req_i.ready = space;
  assign accept      = req_i.valid && space;

  clt_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (req_i.char_in),
    .eol_i    (req_i.end_of_line),
    .push_o   (push)
  );

  clt_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .res_o   (res_o)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the command line tokenizer: directed and random byte streams.
module tb_top;
  import clt_pkg::*;

  localparam int unsigned RandomItems = 950;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned TailCycles  = 4;

  typedef struct packed {
    logic       eol;
    logic [7:0] ch;
  } line_byte_t;

  // Expected token stream, predicted from accepted requests.
  class token_stream_checker;
    res_t        want_q[$];
    logic        esc_pending;
    quote_e      in_quote;
    logic        token_open;
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      esc_pending = 1'b0;
      in_quote    = QUOTE_NONE;
      token_open  = 1'b0;
    endfunction

    function quote_e quote_of(logic [7:0] c);
      if (c == CharDquote) return QUOTE_DOUBLE;
      if (c == CharSquote) return QUOTE_SINGLE;
      return QUOTE_NONE;
    endfunction

    function void push_result(kind_e k, logic [7:0] c);
      want_q.push_back('{kind: k, char_out: c, last: 1'b0});
    endfunction

    function void note_request(logic [7:0] c, logic eol);
      int unsigned n_before;
      logic [7:0]  lit;
      n_before = want_q.size();
      if (eol) begin
        if (token_open || in_quote != QUOTE_NONE) push_result(KIND_TOKEN_END, 8'h00);
        push_result(KIND_LINE_END, 8'h00);
        clear_state();
      end else if (esc_pending) begin
        lit = c;
        if (c == CharN) lit = CharNewline;
        else if (c == CharT) lit = CharTab;
        push_result(KIND_CHAR, lit);
        token_open  = 1'b1;
        esc_pending = 1'b0;
      end else if (c == CharBackslash) begin
        esc_pending = 1'b1;
      end else if (in_quote != QUOTE_NONE) begin
        if (quote_of(c) == in_quote) begin
          push_result(KIND_TOKEN_END, 8'h00);
          in_quote   = QUOTE_NONE;
          token_open = 1'b0;
        end else begin
          push_result(KIND_CHAR, c);
          token_open = 1'b1;
        end
      end else if (quote_of(c) != QUOTE_NONE || c == CharSpace || c == CharTab) begin
        // a quote or separator closes the open token; a quote also opens a new one
        if (token_open) begin
          push_result(KIND_TOKEN_END, 8'h00);
          token_open = 1'b0;
        end
        in_quote = quote_of(c);
      end else begin
        push_result(KIND_CHAR, c);
        token_open = 1'b1;
      end
      if (want_q.size() > n_before) want_q[want_q.size() - 1].last = 1'b1;
    endfunction

    function void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] ch, logic last);
      res_t want;
      if (want_q.size() == 0) begin
        flag_error($sformatf("unexpected result kind=%0d char=%02h last=%0b", kind, ch, last));
        return;
      end
      want = want_q.pop_front();
      if (kind !== want.kind)
        flag_error($sformatf("kind: expected %0d, got %0d", want.kind, kind));
      if (ch !== want.char_out)
        flag_error($sformatf("char_out: expected %02h, got %02h", want.char_out, ch));
      if (last !== want.last)
        flag_error($sformatf("last: expected %0b, got %0b", want.last, last));
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  clt_in_if  req_if ();
  clt_out_if res_if ();

  command_line_tokenizer_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  token_stream_checker sb = new();

  int unsigned burst_left;
  int unsigned sent;
  int unsigned stall_cnt = 0;
  int unsigned rx_cyc    = 0;
  int unsigned rx_mode   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: drive res_if.ready from one of four stall patterns, chosen at random.
  always @(posedge clk) begin
    if (rx_cyc % 50 == 0) rx_mode <= $urandom_range(0, 3);
    rx_cyc <= rx_cyc + 1;
    case (rx_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= 1'($urandom_range(0, 1));
      2: res_if.ready <= (rx_cyc % 4 == 0);
      default: res_if.ready <= (rx_cyc % 32 >= 24);
    endcase
  end

  // Note requests, check results, and watch for a hung handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.char_in, req_if.end_of_line);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.kind, res_if.char_out, res_if.last);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cnt <= 0;
      end else if (req_if.valid || sb.pending() != 0) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= StallLimit) begin
          $display("FAIL command_line_tokenizer_core");
          $finish;
        end
      end
    end
  end

  task automatic idle(int unsigned n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold the request until accepted; when the burst is done, start a new one, usually after a gap.
  task automatic send_request(logic [7:0] c, logic eol);
    req_if.valid       <= 1'b1;
    req_if.char_in     <= c;
    req_if.end_of_line <= eol;
    do @(posedge clk); while (!req_if.ready);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 9) >= 3) idle($urandom_range(1, 6));
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5: return 8'h61 + 8'($urandom_range(0, 25));
      6, 7: return CharSpace;
      8: return CharTab;
      9: return CharDquote;
      10: return CharSquote;
      11: return CharBackslash;
      12: return CharN;
      13: return CharT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  line_byte_t directed_q[$];

  initial begin
    int unsigned len;
    req_if.valid       <= 1'b0;
    req_if.char_in     <= 8'h00;
    req_if.end_of_line <= 1'b0;
    rst_n              <= 1'b0;
    burst_left = 0;
    sent       = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Plain bytes and byte extremes, quote after a token, other quote inside quotes,
    // separators in a row, empty quoted token, escapes outside quotes,
    // escape pending at line end, line end with an empty open quote and an open token.
    directed_q = '{
      '{1'b0, 8'h61}, '{1'b0, 8'hFF}, '{1'b0, 8'h00}, '{1'b0, CharDquote},
      '{1'b0, CharSquote}, '{1'b0, CharDquote}, '{1'b0, CharSpace}, '{1'b0, CharTab},
      '{1'b0, CharSquote}, '{1'b0, CharDquote}, '{1'b0, CharSquote}, '{1'b0, CharSquote},
      '{1'b0, CharSquote}, '{1'b0, CharBackslash}, '{1'b0, CharN},
      '{1'b0, CharBackslash}, '{1'b0, CharT}, '{1'b0, CharBackslash},
      '{1'b0, CharDquote}, '{1'b0, CharSpace}, '{1'b0, CharBackslash}, '{1'b1, 8'hA5},
      '{1'b0, CharDquote}, '{1'b1, 8'h00}, '{1'b0, 8'h62}, '{1'b1, 8'hFF}
    };
    foreach (directed_q[i]) send_request(directed_q[i].ch, directed_q[i].eol);
    wait_drained();

    // Mostly whole lines from a shell-like alphabet, some raw noise.
    while (sent < RandomItems) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 16);
        repeat (len) send_request(8'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0));
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (len) send_request(pick_byte(), 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b1);
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS command_line_tokenizer_core");
    end else begin
      $display("FAIL command_line_tokenizer_core");
    end
    $finish;
  end

endmodule
